// File: design/gdr_pkg.sv
package gdr_pkg;

    localparam int Heads      = 4;
    localparam int HeadDim    = 64;
    localparam int HeadW      = 2;
    localparam int IdxW       = 6;
    localparam int CntW       = 7;
    localparam int AddrW      = HeadW + IdxW + IdxW;
    localparam int MemDepth   = Heads * HeadDim * HeadDim;
    localparam logic [CntW-1:0] DimReset = 7'd64;

    typedef struct packed {
        logic            start;
        logic [HeadW-1:0] head;
        logic [CntW-1:0] dim;
        logic [15:0]     decay;
        logic [15:0]     beta;
    } t_job;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
        if (x > 50'sh7FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (x < -50'sh80000000) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
        if (x > 64'sd32767) begin
            return 16'sh7FFF;
        end else if (x < -64'sd32768) begin
            return 16'sh8000;
        end
        return x[15:0];
    endfunction

endpackage

// File: design/gdr_vec_buf.sv
module gdr_vec_buf (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [gdr_pkg::IdxW-1:0]         i_waddr,
    input  logic signed [15:0]               i_q,
    input  logic signed [15:0]               i_k,
    input  logic signed [15:0]               i_v,
    input  logic [gdr_pkg::IdxW-1:0]         i_raddr,
    input  logic [gdr_pkg::IdxW-1:0]         i_vaddr,
    output logic signed [15:0]               o_q,
    output logic signed [15:0]               o_k,
    output logic signed [15:0]               o_v
);

    logic signed [15:0] r_qm [gdr_pkg::HeadDim];
    logic signed [15:0] r_km [gdr_pkg::HeadDim];
    logic signed [15:0] r_vm [gdr_pkg::HeadDim];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_qm[i_waddr] <= i_q;
            r_km[i_waddr] <= i_k;
            r_vm[i_waddr] <= i_v;
        end
        o_q <= r_qm[i_raddr];
        o_k <= r_km[i_raddr];
        o_v <= r_vm[i_vaddr];
    end

endmodule

// File: design/gdr_state_mem.sv
module gdr_state_mem (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [gdr_pkg::AddrW-1:0]      i_waddr,
    input  logic signed [31:0]             i_wdata,
    input  logic [gdr_pkg::AddrW-1:0]      i_raddr,
    output logic signed [31:0]             o_rdata
);

    logic signed [31:0] r_mem [gdr_pkg::MemDepth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: design/gdr_engine.sv
module gdr_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gdr_pkg::t_job                  i_job,
    output logic                           o_busy,
    output logic [gdr_pkg::IdxW-1:0]       o_buf_addr,
    output logic [gdr_pkg::IdxW-1:0]       o_v_addr,
    input  logic signed [15:0]             i_q,
    input  logic signed [15:0]             i_k,
    input  logic signed [15:0]             i_v,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output logic [23:0]                    o_res_data,
    output logic                           o_res_last
);

    localparam int CntW = gdr_pkg::CntW;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLEAR = 7'b0000010,
        S_DOT   = 7'b0000100,
        S_GATE  = 7'b0001000,
        S_DELTA = 7'b0010000,
        S_UPD   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [gdr_pkg::AddrW-1:0] r_clr;
    logic [gdr_pkg::HeadW-1:0] r_head;
    logic [gdr_pkg::CntW-1:0] r_dim;
    logic [15:0] r_decay, r_beta;
    logic [gdr_pkg::IdxW-1:0] r_j;
    logic [gdr_pkg::CntW-1:0] r_i;
    logic r_rd_v, r_rd_v2;
    logic [gdr_pkg::IdxW-1:0] r_wi;
    logic signed [63:0] r_acc;
    logic signed [47:0] r_prod;
    logic signed [49:0] r_delta;
    logic signed [47:0] r_gr;
    logic signed [15:0] r_vj;
    logic signed [31:0] r_newc;
    logic r_new_v;
    logic signed [15:0] r_qd;
    logic r_res_valid, r_res_last;
    logic [15:0] r_y;
    logic [gdr_pkg::IdxW-1:0] r_ycol;

    logic issue;
    logic signed [31:0] rdata;
    logic mem_we;
    logic [gdr_pkg::AddrW-1:0] mem_waddr, mem_raddr;
    logic signed [31:0] mem_wdata;
    logic signed [49:0] upd_a, upd_b;
    logic signed [65:0] ka;
    logic signed [48:0] gc;

    gdr_state_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rdata)
    );

    assign o_busy     = (r_state != S_IDLE) || r_res_valid;
    assign issue      = (r_state == S_DOT || r_state == S_UPD) && (r_i < r_dim);
    assign o_buf_addr = r_i[gdr_pkg::IdxW-1:0];
    assign o_v_addr   = r_j;
    assign mem_raddr  = {r_head, r_j, r_i[gdr_pkg::IdxW-1:0]};

    assign gc   = 49'(signed'({1'b0, r_decay})) * 49'(rdata);
    assign ka   = 66'(i_k) * 66'(r_delta);
    assign upd_a = 50'((gc + 49'sd16384) >>> 15);
    assign upd_b = 50'((ka + 66'sd2048) >>> 12);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {r_head, r_j, r_wi};
        mem_wdata = gdr_pkg::sat32(upd_a + upd_b);
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else if (r_state == S_UPD && r_rd_v) begin
            mem_we = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_job.start) n_state = S_DOT;
            S_CLEAR: if (&r_clr) n_state = S_IDLE;
            S_DOT:   if (r_i == r_dim && !r_rd_v && !r_rd_v2) n_state = S_GATE;
            S_GATE:  n_state = S_DELTA;
            S_DELTA: n_state = S_UPD;
            S_UPD:   if (r_i == r_dim && !r_rd_v && !r_new_v) n_state = S_OUT;
            S_OUT: begin
                if (!r_res_valid) begin
                    n_state = (CntW'(r_j) + 1'b1 == r_dim) ? S_IDLE : S_DOT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_rd_v      <= 1'b0;
            r_rd_v2     <= 1'b0;
            r_new_v     <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= issue;
            r_wi    <= r_i[gdr_pkg::IdxW-1:0];
            r_rd_v2 <= r_rd_v && r_state == S_DOT;
            r_new_v <= r_rd_v && r_state == S_UPD;
            if (r_res_valid && i_res_ready) r_res_valid <= 1'b0;
            if (issue) r_i <= r_i + 1'b1;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    if (i_job.start) begin
                        r_head  <= i_job.head;
                        r_dim   <= i_job.dim;
                        r_decay <= i_job.decay;
                        r_beta  <= i_job.beta;
                        r_j     <= '0;
                        r_i     <= '0;
                        r_acc   <= '0;
                    end
                end
                S_DOT: begin
                    if (r_rd_v) r_prod <= 48'(rdata) * 48'(i_k);
                    if (r_rd_v2) r_acc <= r_acc + 64'(r_prod);
                    if (r_rd_v) r_vj <= i_v;
                end
                S_DELTA: begin
                    r_i   <= '0;
                    r_acc <= '0;
                end
                S_UPD: begin
                    if (r_rd_v) begin
                        r_newc <= mem_wdata;
                        r_qd   <= i_q;
                    end
                    if (r_new_v) r_acc <= r_acc + 64'(r_newc) * 64'(r_qd);
                end
                S_OUT: begin
                    if (!r_res_valid) begin
                        r_res_valid <= 1'b1;
                        r_y         <= gdr_pkg::sat16((r_acc + 64'sh800000) >>> 24);
                        r_ycol      <= r_j;
                        r_res_last  <= (CntW'(r_j) + 1'b1 == r_dim);
                        r_j         <= r_j + 1'b1;
                        r_i         <= '0;
                        r_acc       <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    logic signed [49:0] ret;
    logic signed [66:0] gmul, bmul;
    logic signed [50:0] diff;
    assign ret  = 50'((r_acc + 64'sd2048) >>> 12);
    assign gmul = 67'(signed'({1'b0, r_decay})) * 67'(ret);
    assign diff = 51'(r_vj) * 51'sd4096 - 51'(r_gr);
    assign bmul = 67'(signed'({1'b0, r_beta})) * 67'(diff);

    always_ff @(posedge i_clk) begin
        if (r_state == S_GATE) begin
            r_gr <= 48'((gmul + 67'sd16384) >>> 15);
        end
        if (r_state == S_DELTA) begin
            r_delta <= 50'((bmul + 67'sd16384) >>> 15);
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res_data  = {r_head, r_ycol, r_y};
    assign o_res_last  = r_res_last;

endmodule

// File: design/gated_delta_rule_recurrence.sv
// channel  | direction | tdata fields (low bit up)          | tuser / tlast
// s_axis   | in        | q_value, k_value, v_value, decay,  | tuser: head
//          |           | beta (80 bits)                     |
// m_axis   | out       | y_value, column (24 bits)          | tuser: head_out,
//          |           |                                    | tlast: last_of_run
// cfg      | in        | head_dim (8 bits)                  |
// Elements are taken one per cycle while the engine is idle. The last element starts a
// sweep of the state memory: two passes over each column through its single read port.
// After reset a clearing pass zeroes all 16384 words of the state; no item is taken then.
// Results wait in one output register; the sweep holds at its next result while that is
// full, and no item is taken until the last result of a sweep has left.
module gated_delta_rule_recurrence (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // q_value, k_value, v_value, decay, beta
    input  logic [1:0]  s_axis_tuser,   // head
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // y_value, column
    output logic [1:0]  m_axis_tuser,   // head_out
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data        // head_dim
);

    logic [gdr_pkg::CntW-1:0] r_head_dim, r_count, dim, idx;
    gdr_pkg::t_job job;
    logic busy, acc;
    logic [gdr_pkg::IdxW-1:0] baddr, vaddr;
    logic signed [15:0] q, k, v;
    logic [23:0] res;

    always_comb begin
        dim = r_head_dim;
        if (r_head_dim < 7'd2) dim = 7'd2;
        if (r_head_dim > gdr_pkg::CntW'(gdr_pkg::HeadDim)) begin
            dim = gdr_pkg::CntW'(gdr_pkg::HeadDim);
        end
        idx = (r_count >= dim) ? '0 : r_count;
    end

    assign s_axis_tready = !busy;
    assign cfg_ready     = 1'b1;
    assign acc           = s_axis_tvalid && s_axis_tready;

    always_comb begin
        job.start = acc && (idx + 1'b1 == dim);
        job.head  = s_axis_tuser;
        job.dim   = dim;
        job.decay = s_axis_tdata[63:48];
        job.beta  = s_axis_tdata[79:64];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_dim <= gdr_pkg::DimReset;
            r_count    <= '0;
        end else if (cfg_valid) begin
            r_head_dim <= cfg_data[6:0];
            r_count    <= '0;
        end else if (acc) begin
            r_count <= job.start ? '0 : idx + 1'b1;
        end
    end

    gdr_vec_buf u_buf (
        .i_clk   (i_clk),
        .i_we    (acc),
        .i_waddr (idx[gdr_pkg::IdxW-1:0]),
        .i_q     (s_axis_tdata[15:0]),
        .i_k     (s_axis_tdata[31:16]),
        .i_v     (s_axis_tdata[47:32]),
        .i_raddr (baddr),
        .i_vaddr (vaddr),
        .o_q     (q),
        .o_k     (k),
        .o_v     (v)
    );

    gdr_engine u_eng (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .o_busy      (busy),
        .o_buf_addr  (baddr),
        .o_v_addr    (vaddr),
        .i_q         (q),
        .i_k         (k),
        .i_v         (v),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res_data  (res),
        .o_res_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, res[21:0]};
    assign m_axis_tuser = res[23:22];

endmodule
